// ===== rtl/core/pme_pkg.sv =====
package pme_pkg;

  // field widths of the channels and registers
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CITY_W     = 6;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned CNT_CFG_W  = 7;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned FACTOR_W   = RATE_W + 1;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // one in q1.16, the base of the evaporation factor
  localparam logic [FACTOR_W-1:0] ONE_Q16 = FACTOR_W'(1) << RATE_W;

  // register reset values
  localparam logic [CNT_CFG_W-1:0] CITY_COUNT_RST = 7'd64;
  localparam logic [RATE_W-1:0]    EVAP_RATE_RST  = '0;
  localparam logic [LEVEL_W-1:0]   MIN_LEVEL_RST  = '0;
  localparam logic [LEVEL_W-1:0]   MAX_LEVEL_RST  = '1;

  typedef enum logic [KIND_W-1:0] {
    OP_FILL    = 3'd0,
    OP_READ    = 3'd1,
    OP_SET     = 3'd2,
    OP_EVAP    = 3'd3,
    OP_DEPOSIT = 3'd4,
    OP_CLAMP   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    REG_CITY_COUNT = 2'd0,
    REG_EVAP_RATE  = 2'd1,
    REG_MIN_LEVEL  = 2'd2,
    REG_MAX_LEVEL  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_DATA,
    ST_SET_MIRROR,
    ST_DEP_AB,
    ST_DEP_BA,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // read address source
  typedef enum logic [1:0] {
    RSEL_AB_LIVE,
    RSEL_BA,
    RSEL_SWEEP
  } rsel_e;

  // point write address source
  typedef enum logic [1:0] {
    WSEL_AB_LIVE,
    WSEL_AB,
    WSEL_BA
  } wsel_e;

  // point write data source
  typedef enum logic [1:0] {
    WDAT_LIVE,
    WDAT_ITEM,
    WDAT_SAT
  } wdat_e;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] city_count;
    logic [RATE_W-1:0]    evap_rate;
    logic [LEVEL_W-1:0]   min_level;
    logic [LEVEL_W-1:0]   max_level;
  } cfg_t;

  typedef struct packed {
    logic  accept;
    logic  re;
    rsel_e rsel;
    logic  pwe;
    wsel_e wsel;
    wdat_e wdat;
    logic  sweep_init;
    logic  sweep_step;
    logic  capture_read;
    logic  push;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  point_ok;
    logic  self_loop;
    logic  sweep_last;
    logic  sweep_none;
    logic  pipe_busy;
    logic  out_free;
  } stat_t;

endpackage

// ===== rtl/core/pme_op_if.sv =====
interface pme_op_if import pme_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CITY_W-1:0]   city_from;
  logic [CITY_W-1:0]   city_to;
  logic [LEVEL_W-1:0]  level;

  modport source (output valid, kind, city_from, city_to, level, input ready);
  modport sink   (input valid, kind, city_from, city_to, level, output ready);
endinterface

// ===== rtl/core/pme_res_if.sv =====
interface pme_res_if import pme_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] read_level;

  modport source (output valid, read_level, input ready);
  modport sink   (input valid, read_level, output ready);
endinterface

// ===== rtl/core/pheromone_matrix_engine_top.sv =====
// channel     dir  transfer when         payload
// op_in       in   valid & ready         kind, city_from, city_to, level
// res_out     out  valid & ready         read_level
// apb         in   psel&penable&pwrite   paddr[3:2] selects register, pwdata
//
// fill, evaporate and clamp sweep the n*n entries with n = min(city_count, MAX_CITIES),
// one table entry per cycle through the single write port of the table ram;
// a deposit to a city paired with itself writes that one entry only
// reset restores the registers; the table is undefined until written, no clear pass
// a result waiting in res_out does not block the next transfer on op_in
module pheromone_matrix_engine_top import pme_pkg::*; #(
  parameter int unsigned MAX_CITIES = 64,
  parameter int unsigned LEVEL_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pme_op_if.sink                op_in,
  pme_res_if.source             res_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // configuration registers behind the apb port
  pme_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one item at a time, drives the datapath by commands
  pme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (op_in.valid),
    .in_ready_o (op_in.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table ram, sweep pipeline, point update logic and result register
  pme_datapath #(
    .MAX_CITIES (MAX_CITIES),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (op_in.kind),
    .city_from_i  (op_in.city_from),
    .city_to_i    (op_in.city_to),
    .level_i      (op_in.level),
    .out_ready_i  (res_out.ready),
    .out_valid_o  (res_out.valid),
    .read_level_o (res_out.read_level)
  );

endmodule

// ===== rtl/core/pme_ram.sv =====
module pme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pme_cfg_regs.sv =====
module pme_cfg_regs import pme_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_CITY_COUNT: cfg_d.city_count = pwdata[CNT_CFG_W-1:0];
        REG_EVAP_RATE:  cfg_d.evap_rate  = pwdata[RATE_W-1:0];
        REG_MIN_LEVEL:  cfg_d.min_level  = pwdata[LEVEL_W-1:0];
        REG_MAX_LEVEL:  cfg_d.max_level  = pwdata[LEVEL_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CITY_COUNT: prdata = APB_DATA_W'(cfg_q.city_count);
      REG_EVAP_RATE:  prdata = APB_DATA_W'(cfg_q.evap_rate);
      REG_MIN_LEVEL:  prdata = APB_DATA_W'(cfg_q.min_level);
      REG_MAX_LEVEL:  prdata = APB_DATA_W'(cfg_q.max_level);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.city_count <= CITY_COUNT_RST;
      cfg_q.evap_rate  <= EVAP_RATE_RST;
      cfg_q.min_level  <= MIN_LEVEL_RST;
      cfg_q.max_level  <= MAX_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/pme_ctrl.sv =====
module pme_ctrl import pme_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (stat_i.kind) inside
            OP_FILL, OP_EVAP, OP_CLAMP: begin
              cmd_o.sweep_init = 1'b1;
              state_d = stat_i.sweep_none ? ST_FINISH : ST_SWEEP;
            end
            OP_READ: begin
              if (stat_i.point_ok) begin
                cmd_o.re   = 1'b1;
                cmd_o.rsel = RSEL_AB_LIVE;
                state_d    = ST_READ_DATA;
              end else begin
                state_d = ST_FINISH;
              end
            end
            OP_SET: begin
              if (stat_i.point_ok) begin
                cmd_o.pwe  = 1'b1;
                cmd_o.wsel = WSEL_AB_LIVE;
                cmd_o.wdat = WDAT_LIVE;
                state_d    = ST_SET_MIRROR;
              end else begin
                state_d = ST_FINISH;
              end
            end
            OP_DEPOSIT: begin
              if (stat_i.point_ok) begin
                cmd_o.re   = 1'b1;
                cmd_o.rsel = RSEL_AB_LIVE;
                state_d    = ST_DEP_AB;
              end else begin
                state_d = ST_FINISH;
              end
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_READ_DATA: begin
        cmd_o.capture_read = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SET_MIRROR: begin
        cmd_o.pwe  = 1'b1;
        cmd_o.wsel = WSEL_BA;
        cmd_o.wdat = WDAT_ITEM;
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DEP_AB: begin
        cmd_o.pwe  = 1'b1;
        cmd_o.wsel = WSEL_AB;
        cmd_o.wdat = WDAT_SAT;
        if (stat_i.self_loop) begin
          if (stat_i.out_free) begin
            cmd_o.push = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          cmd_o.re   = 1'b1;
          cmd_o.rsel = RSEL_BA;
          state_d    = ST_DEP_BA;
        end
      end
      ST_DEP_BA: begin
        cmd_o.pwe  = 1'b1;
        cmd_o.wsel = WSEL_BA;
        cmd_o.wdat = WDAT_SAT;
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SWEEP: begin
        cmd_o.re         = 1'b1;
        cmd_o.rsel       = RSEL_SWEEP;
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last entry leaves the read stage before the result goes out
        if (!stat_i.pipe_busy && stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/pme_datapath.sv =====
module pme_datapath import pme_pkg::*; #(
  parameter int unsigned MAX_CITIES = 64,
  parameter int unsigned LEVEL_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [CITY_W-1:0]  city_from_i,
  input  logic [CITY_W-1:0]  city_to_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [LEVEL_W-1:0] read_level_o
);

  localparam int unsigned Depth = MAX_CITIES * MAX_CITIES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW  = $clog2(MAX_CITIES);
  localparam int unsigned CntW  = $clog2(MAX_CITIES + 1);
  localparam int unsigned PpW   = 32 + FACTOR_W;

  // live item decode, used in the accept cycle
  logic [AddrW-1:0]      ab_live, ba_live;
  logic [LEVEL_BITS-1:0] lv_live;
  logic                  point_ok_live;

  assign ab_live = AddrW'(city_from_i) * AddrW'(MAX_CITIES) + AddrW'(city_to_i);
  assign ba_live = AddrW'(city_to_i) * AddrW'(MAX_CITIES) + AddrW'(city_from_i);
  assign lv_live = LEVEL_BITS'(level_i);
  assign point_ok_live = (32'(city_from_i) < MAX_CITIES) && (32'(city_to_i) < MAX_CITIES);

  // item registers
  kind_e                 kind_q;
  logic [AddrW-1:0]      ab_q, ba_q;
  logic [LEVEL_BITS-1:0] lv_q;
  logic                  self_loop_q;
  logic [LEVEL_W-1:0]    hold_q;

  // sweep cursor
  logic [IdxW-1:0]  col_q, row_q;
  logic [AddrW-1:0] base_q;
  logic [CntW-1:0]  n_cities;
  logic             col_last, row_last;
  logic [AddrW-1:0] sweep_addr;

  assign n_cities = (32'(cfg_i.city_count) > MAX_CITIES) ? CntW'(MAX_CITIES)
                                                          : CntW'(cfg_i.city_count);
  assign col_last   = (CntW'(col_q) + CntW'(1)) == n_cities;
  assign row_last   = (CntW'(row_q) + CntW'(1)) == n_cities;
  assign sweep_addr = base_q + AddrW'(col_q);

  // ram
  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_waddr, ram_raddr, pt_waddr;
  logic [LEVEL_BITS-1:0] ram_wdata, ram_rdata, pt_wdata;

  // sweep pipeline: stage 1 holds the read, stage 2 the write
  logic                  s1_vld_q, s2_vld_q;
  logic [AddrW-1:0]      s1_addr_q, s2_addr_q;
  logic                  s2_evap_q;
  logic [PpW-1:0]        s2_pp_lo_q, s2_pp_hi_q;
  logic [LEVEL_BITS-1:0] s2_val_q;

  // saturating add for deposit
  logic [LEVEL_BITS:0]   dep_sum;
  logic [LEVEL_BITS-1:0] dep_sat;

  assign dep_sum = {1'b0, ram_rdata} + {1'b0, lv_q};
  assign dep_sat = dep_sum[LEVEL_BITS] ? '1 : dep_sum[LEVEL_BITS-1:0];

  // evaporation partial products, split at bit 32
  logic [FACTOR_W-1:0]   factor;
  logic [63:0]           x64, evap_sum;
  logic [PpW-1:0]        pp_lo, pp_hi;
  logic [LEVEL_BITS-1:0] evap_res;

  assign factor = ONE_Q16 - FACTOR_W'(cfg_i.evap_rate);
  assign x64    = 64'(ram_rdata);
  assign pp_lo  = PpW'(x64[31:0]) * PpW'(factor);
  assign pp_hi  = PpW'(x64[63:32]) * PpW'(factor);
  assign evap_sum = (64'(s2_pp_hi_q) << RATE_W) + 64'(s2_pp_lo_q >> RATE_W);
  assign evap_res = LEVEL_BITS'(evap_sum);

  // clamp, max first then min so that min wins when the bounds cross
  logic [63:0]           c_max, c_min, c_hi;
  logic [LEVEL_BITS-1:0] clamp_val;

  assign c_max     = 64'(cfg_i.max_level);
  assign c_min     = 64'(cfg_i.min_level);
  assign c_hi      = (x64 > c_max) ? c_max : x64;
  assign clamp_val = LEVEL_BITS'((c_hi < c_min) ? c_min : c_hi);

  always_comb begin
    unique case (cmd_i.wsel)
      WSEL_AB_LIVE: pt_waddr = ab_live;
      WSEL_AB:      pt_waddr = ab_q;
      WSEL_BA:      pt_waddr = ba_q;
      default:      pt_waddr = ab_q;
    endcase
    unique case (cmd_i.wdat)
      WDAT_LIVE: pt_wdata = lv_live;
      WDAT_ITEM: pt_wdata = lv_q;
      WDAT_SAT:  pt_wdata = dep_sat;
      default:   pt_wdata = lv_q;
    endcase
    unique case (cmd_i.rsel)
      RSEL_AB_LIVE: ram_raddr = ab_live;
      RSEL_BA:      ram_raddr = ba_q;
      RSEL_SWEEP:   ram_raddr = sweep_addr;
      default:      ram_raddr = ab_live;
    endcase
  end

  assign ram_re    = cmd_i.re;
  assign ram_we    = s2_vld_q | cmd_i.pwe;
  assign ram_waddr = s2_vld_q ? s2_addr_q : pt_waddr;
  assign ram_wdata = s2_vld_q ? (s2_evap_q ? evap_res : s2_val_q) : pt_wdata;

  pme_ram #(
    .WIDTH (LEVEL_BITS),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q      <= kind_e'(kind_i);
      ab_q        <= ab_live;
      ba_q        <= ba_live;
      lv_q        <= lv_live;
      self_loop_q <= city_from_i == city_to_i;
      hold_q      <= '0;
    end else if (cmd_i.capture_read) begin
      hold_q <= LEVEL_W'(ram_rdata);
    end
    if (cmd_i.sweep_init) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else if (cmd_i.sweep_step) begin
      if (col_last) begin
        col_q  <= '0;
        row_q  <= row_q + IdxW'(1);
        base_q <= base_q + AddrW'(MAX_CITIES);
      end else begin
        col_q <= col_q + IdxW'(1);
      end
    end
    s1_addr_q  <= sweep_addr;
    s2_addr_q  <= s1_addr_q;
    s2_evap_q  <= kind_q == OP_EVAP;
    s2_pp_lo_q <= pp_lo;
    s2_pp_hi_q <= pp_hi;
    s2_val_q   <= (kind_q == OP_FILL) ? lv_q : clamp_val;
  end

  // result register
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] out_level_q, push_val;

  assign push_val = cmd_i.capture_read ? LEVEL_W'(ram_rdata) : hold_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_level_q <= push_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_vld_q    <= cmd_i.sweep_step;
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_level_o = out_level_q;

  assign stat_o.kind       = kind_e'(kind_i);
  assign stat_o.point_ok   = point_ok_live;
  assign stat_o.self_loop  = self_loop_q;
  assign stat_o.sweep_last = col_last & row_last;
  assign stat_o.sweep_none = n_cities == '0;
  assign stat_o.pipe_busy  = s1_vld_q;
  assign stat_o.out_free   = ~out_valid_q | out_ready_i;

endmodule

// ===== rtl/core/pme_checker.sv =====
module pme_checker import pme_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [LEVEL_W-1:0] out_level_i
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q, pend_d;

  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;
  assign pend_d   = pend_q + 2'(in_xfer) - 2'(out_xfer);

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_level_i))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("item taken while previous one in work");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items in flight");

endmodule

bind pheromone_matrix_engine_top pme_checker u_pme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (op_in.valid),
  .in_ready_i  (op_in.ready),
  .out_valid_i (res_out.valid),
  .out_ready_i (res_out.ready),
  .out_level_i (res_out.read_level)
);

// ===== bench/pme_trail_checker.sv =====
`timescale 1ns / 1ps

module pme_trail_checker import pme_pkg::*; #(
  parameter int unsigned MAX_CITIES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pme_op_if                     op_mon,
  pme_res_if                    res_mon,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int unsigned           mismatches_o,
  output int unsigned           levels_due_o
);

  logic [LEVEL_W-1:0]   trail_q [MAX_CITIES][MAX_CITIES];
  logic [CNT_CFG_W-1:0] cities_q;
  logic [RATE_W-1:0]    rate_q;
  logic [LEVEL_W-1:0]   floor_q;
  logic [LEVEL_W-1:0]   ceil_q;
  logic [LEVEL_W-1:0]   read_levels_due [$];
  logic [LEVEL_W-1:0]   due_level;
  int unsigned          mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  function automatic logic [LEVEL_W-1:0] sat_sum(input logic [LEVEL_W-1:0] a,
                                                 input logic [LEVEL_W-1:0] b);
    logic [LEVEL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[LEVEL_W] ? '1 : sum[LEVEL_W-1:0];
  endfunction

  // updates the table copy and returns the level the result should carry
  function automatic logic [LEVEL_W-1:0] apply_trail_op(input logic [KIND_W-1:0]  kind,
                                                        input logic [CITY_W-1:0]  row,
                                                        input logic [CITY_W-1:0]  col,
                                                        input logic [LEVEL_W-1:0] level);
    int unsigned         n;
    int unsigned         i;
    int unsigned         j;
    logic [FACTOR_W-1:0] keep;
    logic [63:0]         scaled;
    logic [LEVEL_W-1:0]  e;
    logic                point_ok;
    n        = (cities_q > MAX_CITIES) ? MAX_CITIES : cities_q;
    keep     = ONE_Q16 - FACTOR_W'(rate_q);
    point_ok = (row < MAX_CITIES) && (col < MAX_CITIES);
    case (kind)
      OP_FILL, OP_EVAP, OP_CLAMP: begin
        for (i = 0; i < n; i++) begin
          for (j = 0; j < n; j++) begin
            e = trail_q[i][j];
            if (kind == OP_FILL) begin
              e = level;
            end else if (kind == OP_EVAP) begin
              scaled = 64'(e) * 64'(keep);
              e      = scaled[LEVEL_W+15:16];
            end else begin
              if (e > ceil_q) e = ceil_q;
              if (e < floor_q) e = floor_q;
            end
            trail_q[i][j] = e;
          end
        end
      end
      OP_READ: begin
        if (point_ok) return trail_q[row][col];
      end
      OP_SET: begin
        if (point_ok) begin
          trail_q[row][col] = level;
          trail_q[col][row] = level;
        end
      end
      OP_DEPOSIT: begin
        if (point_ok) begin
          trail_q[row][col] = sat_sum(trail_q[row][col], level);
          // a city paired with itself is only topped up once
          if (row != col) trail_q[col][row] = sat_sum(trail_q[col][row], level);
        end
      end
      default: ;
    endcase
    return '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cities_q = CITY_COUNT_RST;
      rate_q   = EVAP_RATE_RST;
      floor_q  = MIN_LEVEL_RST;
      ceil_q   = MAX_LEVEL_RST;
      read_levels_due.delete();
      levels_due_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_CITY_COUNT: cities_q = pwdata_i[CNT_CFG_W-1:0];
          REG_EVAP_RATE:  rate_q   = pwdata_i[RATE_W-1:0];
          REG_MIN_LEVEL:  floor_q  = pwdata_i[LEVEL_W-1:0];
          REG_MAX_LEVEL:  ceil_q   = pwdata_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (op_mon.valid && op_mon.ready) begin
        read_levels_due.push_back(apply_trail_op(op_mon.kind, op_mon.city_from,
                                                 op_mon.city_to, op_mon.level));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (read_levels_due.size() == 0) begin
          $error("read_level: expected no transfer, actual %08h", res_mon.read_level);
          mismatch_cnt++;
        end else begin
          due_level = read_levels_due.pop_front();
          if (res_mon.read_level !== due_level) begin
            $error("read_level: expected %08h, actual %08h", due_level, res_mon.read_level);
            mismatch_cnt++;
          end
        end
      end
      levels_due_o <= read_levels_due.size();
    end
  end

endmodule

// ===== bench/tb_pheromone_matrix_engine_top.sv =====
`timescale 1ns / 1ps

module tb_pheromone_matrix_engine_top;
  import pme_pkg::*;

  localparam int unsigned MAX_CITIES  = 64;
  // longest quiet stretch of a correct run is a full 64 x 64 sweep
  // plus the longest receiver stall and sender gap; allow several times that
  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 150;

  // kinds the block has no operation for, it answers them with zero
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = OP_CLAMP + 1'b1;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pme_op_if  op_if ();
  pme_res_if res_if ();

  int unsigned          mismatches;
  int unsigned          levels_due;
  int unsigned          idle_cycles = 0;
  int unsigned          burst_left  = 0;
  int unsigned          stall_left  = 0;
  int unsigned          calm_left   = 0;
  // city count as last written, only used to shape the stimulus
  logic [CNT_CFG_W-1:0] cities_cfg  = CITY_COUNT_RST;

  pheromone_matrix_engine_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_in   (op_if),
    .res_out (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pme_trail_checker #(
    .MAX_CITIES (MAX_CITIES)
  ) trail_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_mon       (op_if),
    .res_mon      (res_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .levels_due_o (levels_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side back-pressure: calm stretches, hard stalls and random flicker
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (calm_left != 0) begin
      res_if.ready <= 1'b1;
      calm_left    <= calm_left - 1;
    end else begin
      case ($urandom_range(0, 5))
        0:       calm_left  <= $urandom_range(20, 120);
        1:       stall_left <= $urandom_range(1, 20);
        default: res_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog: any transfer on any port counts as progress
  always @(posedge clk_i) begin
    if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[pheromone_matrix_engine_top] ERROR");
    $finish;
  end

  // setup phase then access phase, with psel dropped after so writes never overlap
  task automatic write_register(input reg_idx_e idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CNT_CFG_W-1:0] cities,
                           input logic [RATE_W-1:0]    rate,
                           input logic [LEVEL_W-1:0]   floor_level,
                           input logic [LEVEL_W-1:0]   ceil_level);
    write_register(REG_CITY_COUNT, APB_DATA_W'(cities));
    write_register(REG_EVAP_RATE, APB_DATA_W'(rate));
    write_register(REG_MIN_LEVEL, APB_DATA_W'(floor_level));
    write_register(REG_MAX_LEVEL, APB_DATA_W'(ceil_level));
    cities_cfg = cities;
  endtask

  // one operation, presented in bursts with random gaps between them;
  // returns in the time step of its transfer with valid still high
  task automatic issue_op(input logic [KIND_W-1:0]  kind,
                          input logic [CITY_W-1:0]  row,
                          input logic [CITY_W-1:0]  col,
                          input logic [LEVEL_W-1:0] level);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        op_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    op_if.valid     <= 1'b1;
    op_if.kind      <= kind;
    op_if.city_from <= row;
    op_if.city_to   <= col;
    op_if.level     <= level;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
  endtask

  // sender holds off until every result is back and the block is idle again
  task automatic settle_results();
    op_if.valid <= 1'b0;
    @(posedge clk_i);
    while (levels_due != 0) @(posedge clk_i);
    // the sweep tail may still be retiring after its result went out
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CITY_W-1:0] pick_city();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    // bias towards the cities in use so sweeps and point ops meet
    if (roll < 5 && cities_cfg != 0 && cities_cfg <= MAX_CITIES)
      return CITY_W'($urandom_range(0, cities_cfg - 1));
    return CITY_W'($urandom);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return LEVEL_W'($urandom_range(0, 32'h0004_0000));
      3:       return {16'hFFFF, 16'($urandom)};
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  task automatic issue_random_op();
    int unsigned       roll;
    int unsigned       sweep_odds;
    logic [CITY_W-1:0] row;
    logic [CITY_W-1:0] col;
    logic [LEVEL_W-1:0] amount;
    // full-size sweeps are long, keep them rare
    sweep_odds = (cities_cfg > 12) ? 1 : 12;
    roll       = $urandom_range(0, 99);
    row        = pick_city();
    col        = ($urandom_range(0, 6) == 0) ? row : pick_city();
    amount     = ($urandom_range(0, 4) == 0) ? pick_level()
                                             : LEVEL_W'($urandom_range(0, 32'h0002_0000));
    if (roll < sweep_odds) begin
      case ($urandom_range(0, 2))
        0:       issue_op(OP_FILL, row, col, pick_level());
        1:       issue_op(OP_EVAP, row, col, pick_level());
        default: issue_op(OP_CLAMP, row, col, pick_level());
      endcase
    end else if (roll < sweep_odds + 3) begin
      issue_op(($urandom_range(0, 1) != 0) ? KIND_SPARE_LAST : KIND_SPARE_FIRST,
               row, col, pick_level());
    end else if (roll < 40) begin
      issue_op(OP_READ, row, col, pick_level());
    end else if (roll < 60) begin
      issue_op(OP_SET, row, col, pick_level());
    end else begin
      issue_op(OP_DEPOSIT, row, col, amount);
    end
  endtask

  initial begin
    logic [CNT_CFG_W-1:0] cities;
    logic [RATE_W-1:0]    rate;
    logic [LEVEL_W-1:0]   floor_level;
    logic [LEVEL_W-1:0]   ceil_level;

    // everything known before the first edge
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    op_if.valid     = 1'b0;
    op_if.kind      = OP_FILL;
    op_if.city_from = '0;
    op_if.city_to   = '0;
    op_if.level     = '0;
    res_if.ready    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings cover the whole 64 x 64 table, so this fill writes
    // every entry before anything reads one
    issue_op(OP_FILL, '0, '0, 32'h0001_0000);
    issue_op(OP_READ, '0, '0, '1);
    issue_op(OP_READ, '1, '1, '0);
    // set lands on the mirror too, then deposit saturates at full scale
    issue_op(OP_SET, '0, '1, '1);
    issue_op(OP_READ, '1, '0, '0);
    issue_op(OP_DEPOSIT, '0, '1, 32'h0000_0001);
    issue_op(OP_READ, '0, '1, '0);
    // a city paired with itself is only topped up once
    issue_op(OP_SET, 6'd5, 6'd5, '0);
    issue_op(OP_DEPOSIT, 6'd5, 6'd5, 32'h0000_0007);
    issue_op(OP_READ, 6'd5, 6'd5, '0);
    // two half-scale deposits from either side overflow the entry
    issue_op(OP_DEPOSIT, 6'd1, 6'd2, 32'h8000_0000);
    issue_op(OP_DEPOSIT, 6'd2, 6'd1, 32'h8000_0000);
    issue_op(OP_READ, 6'd2, 6'd1, '0);
    // unused kinds are answered with zero and change nothing
    issue_op(KIND_SPARE_FIRST, '1, '1, '1);
    issue_op(KIND_SPARE_LAST, '0, '0, '0);
    // zero rate and the widest bounds leave the table as it is
    issue_op(OP_EVAP, '0, '0, '0);
    issue_op(OP_CLAMP, '0, '0, '0);
    issue_op(OP_READ, '0, '1, '0);

    // count beyond the table saturates, full rate, min above max
    settle_results();
    configure(7'd127, '1, 32'h0002_0000, 32'h0001_0000);
    issue_op(OP_EVAP, '0, '0, '0);
    issue_op(OP_READ, '1, '1, '0);
    issue_op(OP_CLAMP, '0, '0, '0);
    issue_op(OP_READ, 6'd1, 6'd2, '0);

    // no cities in use: sweeps leave every entry alone
    settle_results();
    configure('0, 16'h8000, '0, '1);
    issue_op(OP_FILL, '0, '0, '1);
    issue_op(OP_EVAP, '0, '0, '0);
    issue_op(OP_CLAMP, '0, '0, '0);
    issue_op(OP_READ, '0, '0, '0);

    // random phases, each under its own register settings
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle_results();
      case (phase)
        0:       cities = 7'd3;
        1:       cities = 7'd1;
        2:       cities = 7'd8;
        3:       cities = 7'd64;
        4:       cities = 7'd2;
        5:       cities = 7'd0;
        6:       cities = 7'd12;
        7:       cities = 7'd127;
        default: cities = CNT_CFG_W'($urandom_range(1, 10));
      endcase
      case (phase)
        1:       rate = '1;
        2:       rate = '0;
        default: rate = RATE_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: begin
          floor_level = '0;
          ceil_level  = '1;
        end
        1: begin
          // any order, min above max included
          floor_level = LEVEL_W'($urandom);
          ceil_level  = LEVEL_W'($urandom);
        end
        default: begin
          floor_level = LEVEL_W'($urandom_range(0, 32'h0000_8000));
          ceil_level  = floor_level + LEVEL_W'($urandom_range(32'h0000_1000, 32'h0008_0000));
        end
      endcase
      configure(cities, rate, floor_level, ceil_level);
      repeat (PHASE_ITEMS) begin
        issue_random_op();
        // now and then the sender waits for the block to empty completely
        if ($urandom_range(0, 199) == 0) settle_results();
      end
    end

    // drain, then give any stray result time to show up
    settle_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[pheromone_matrix_engine_top] OK");
    end else begin
      $display("[pheromone_matrix_engine_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pme_pkg.sv
rtl/core/pme_op_if.sv
rtl/core/pme_res_if.sv
rtl/core/pme_ram.sv
rtl/core/pme_cfg_regs.sv
rtl/core/pme_ctrl.sv
rtl/core/pme_datapath.sv
rtl/core/pheromone_matrix_engine_top.sv
rtl/core/pme_checker.sv
bench/pme_trail_checker.sv
bench/tb_pheromone_matrix_engine_top.sv
